@@ rtl/core/script_token_splitter_macros.svh @@
// Assertion macros shared by the token splitter modules.
// Depends on nothing; files that check their own logic include it by bare name.
`ifndef SCRIPT_TOKEN_SPLITTER_MACROS_SVH
`define SCRIPT_TOKEN_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define STSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define STSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/stsp_pkg.sv @@
// Shared constants and controller/datapath types for the token splitter.
// Depends on nothing; used by every module of the block.
package stsp_pkg;

	localparam int unsigned TOKEN_MAX_DEF = 32;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic       keep;
		logic       keep_first;
		logic       len_clr;
		logic       idx_clr;
		logic       idx_inc;
		logic       rd_en;
		logic       out_load;
		logic [1:0] out_kind;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic len_full;
		logic idx_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/stsp_if.sv @@
// Valid/ready channel interfaces for the text byte input and the token output.
// Depends on nothing.
interface stsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface stsp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] char_value;
	logic [4:0] char_index;
	logic       run_last;
	modport source(output valid, output item_kind, output char_value, output char_index,
		output run_last, input ready);
	modport sink(input valid, input item_kind, input char_value, input char_index,
		input run_last, output ready);
endinterface

@@ rtl/core/stsp_datapath.sv @@
// Datapath: token store, length and read index counters, output register.
// Depends on stsp_pkg, stsp_out_if and the assertion macro header.
`include "script_token_splitter_macros.svh"
module stsp_datapath #(
	parameter int unsigned TOKEN_MAX = stsp_pkg::TOKEN_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          in_byte,
	input  stsp_pkg::cmd_t      cmd,
	output stsp_pkg::stat_t     stat,
	stsp_out_if.source          out_ch
);

	localparam int unsigned IW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
	localparam int unsigned LW = $clog2(TOKEN_MAX + 1);

	logic [7:0]    store_q [TOKEN_MAX];
	logic [7:0]    rdata_q;
	logic [LW-1:0] len_q;
	logic [IW-1:0] idx_q;
	logic          valid_q;
	logic [1:0]    kind_q;
	logic [7:0]    char_q;
	logic [4:0]    cidx_q;
	logic          last_q;

	logic          len_full;
	logic          wr_en;
	logic [IW-1:0] wr_addr;

	assign len_full = (len_q == LW'(TOKEN_MAX));
	assign wr_en    = cmd.keep_first || (cmd.keep && !len_full);
	assign wr_addr  = cmd.keep_first ? '0 : len_q[IW-1:0];

	assign stat.len_zero = (len_q == '0);
	assign stat.len_full = len_full;
	assign stat.idx_last = ((LW'(idx_q) + LW'(1)) == len_q);
	assign stat.out_free = !valid_q || out_ch.ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= in_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= store_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			priority if (cmd.len_clr) begin
				len_q <= '0;
			end else if (cmd.keep_first) begin
				len_q <= LW'(1);
			end else if (cmd.keep && !len_full) begin
				len_q <= len_q + LW'(1);
			end else begin
				len_q <= len_q;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Only character beats carry a value and a position; the others send zeros.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			last_q <= cmd.out_last;
			if (cmd.out_kind == stsp_pkg::KIND_CHAR) begin
				char_q <= rdata_q;
				cidx_q <= 5'(idx_q);
			end else begin
				char_q <= '0;
				cidx_q <= '0;
			end
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.item_kind  = kind_q;
	assign out_ch.char_value = char_q;
	assign out_ch.char_index = cidx_q;
	assign out_ch.run_last   = last_q;

	`STSP_ASSERT_IMP(a_len_bound, clk, arst_n, 1'b1, len_q <= LW'(TOKEN_MAX), "token length overflow")
	`STSP_ASSERT_IMP(a_rd_in_token, clk, arst_n, cmd.rd_en, LW'(idx_q) < len_q, "read past token end")

endmodule

@@ rtl/core/stsp_ctrl.sv @@
// Controller: scan mode tracking and the sequencer that emits token beats.
// Depends on stsp_pkg and the assertion macro header.
`include "script_token_splitter_macros.svh"
module stsp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	output logic            in_ready,
	input  stsp_pkg::stat_t stat,
	output stsp_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		M_SKIP,
		M_SLASH,
		M_COMMENT,
		M_QUOTE,
		M_WORD
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_PUT,
		S_EMPTY,
		S_END
	} state_t;

	mode_t  mode_q, mode_d, eff_mode;
	state_t state_q, state_d;
	logic   end_q, end_d;
	logic   accept;
	logic   is_ws;
	logic   emit, empty, fin;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_ready && in_valid;
	assign is_ws    = (in_byte <= stsp_pkg::CH_SPACE);

	always_comb begin
		cmd      = '0;
		mode_d   = mode_q;
		state_d  = state_q;
		end_d    = end_q;
		emit     = 1'b0;
		empty    = 1'b0;
		fin      = 1'b0;
		// A slash that is not followed by another slash opens a word.
		eff_mode = (mode_q == M_SLASH) ? M_WORD : mode_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode_q == M_SLASH && in_byte == stsp_pkg::CH_SLASH) begin
						mode_d      = M_COMMENT;
						cmd.len_clr = 1'b1;
					end else begin
						mode_d = eff_mode;
						unique case (eff_mode)
							M_COMMENT: begin
								if (in_byte == stsp_pkg::CH_NUL) begin
									fin = 1'b1;
								end else if (in_byte == stsp_pkg::CH_NL) begin
									mode_d = M_SKIP;
								end
							end
							M_QUOTE: begin
								if (in_byte == stsp_pkg::CH_QUOTE) begin
									emit   = 1'b1;
									empty  = stat.len_zero;
									mode_d = M_SKIP;
								end else if (in_byte == stsp_pkg::CH_NUL) begin
									emit  = 1'b1;
									empty = stat.len_zero;
									fin   = 1'b1;
								end else begin
									cmd.keep = 1'b1;
								end
							end
							M_WORD: begin
								if (!is_ws) begin
									cmd.keep = 1'b1;
								end else begin
									// A word that filled the store is reported as empty.
									emit   = 1'b1;
									empty  = stat.len_zero || stat.len_full;
									mode_d = M_SKIP;
									fin    = (in_byte == stsp_pkg::CH_NUL);
								end
							end
							default: begin
								if (in_byte == stsp_pkg::CH_NUL) begin
									fin = 1'b1;
								end else if (is_ws) begin
									mode_d = M_SKIP;
								end else if (in_byte == stsp_pkg::CH_SLASH) begin
									cmd.keep_first = 1'b1;
									mode_d         = M_SLASH;
								end else if (in_byte == stsp_pkg::CH_QUOTE) begin
									cmd.len_clr = 1'b1;
									mode_d      = M_QUOTE;
								end else begin
									cmd.keep_first = 1'b1;
									mode_d         = M_WORD;
								end
							end
						endcase
					end
					end_d = fin;
					priority if (emit && empty) begin
						state_d = S_EMPTY;
					end else if (emit) begin
						cmd.idx_clr = 1'b1;
						state_d     = S_RD;
					end else if (fin) begin
						state_d = S_END;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_PUT;
			end
			S_PUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = stsp_pkg::KIND_CHAR;
					cmd.out_last = stat.idx_last && !end_q;
					if (stat.idx_last) begin
						state_d = end_q ? S_END : S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_RD;
					end
				end
			end
			S_EMPTY: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = stsp_pkg::KIND_EMPTY;
					cmd.out_last = !end_q;
					state_d      = end_q ? S_END : S_IDLE;
				end
			end
			S_END: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = stsp_pkg::KIND_END;
					cmd.out_last = 1'b1;
					cmd.len_clr  = 1'b1;
					mode_d       = M_SKIP;
					end_d        = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= M_SKIP;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			end_q   <= end_d;
		end
	end

	`STSP_ASSERT_NXT(a_rd_then_put, clk, arst_n, state_q == S_RD, state_q == S_PUT, "read not followed by put")
	`STSP_ASSERT_IMP(a_end_is_last, clk, arst_n, cmd.out_load && cmd.out_kind == stsp_pkg::KIND_END, cmd.out_last, "end marker not last")
	`STSP_ASSERT_NXT(a_end_resets, clk, arst_n, cmd.out_load && cmd.out_kind == stsp_pkg::KIND_END, state_q == S_IDLE && mode_q == M_SKIP && !end_q, "end marker did not reset scan")

endmodule

@@ rtl/core/script_token_splitter.sv @@
// Script token splitter: takes text one byte per beat on in_ch, skips blanks and
// "//" comments at a token start, and sends each finished word or quoted string on
// out_ch as one beat per character (or one empty-token beat), then an end-of-text
// beat on byte 0. in_ch.ready stays low until every beat caused by a byte is
// loaded into the output register, so a stall on out_ch holds off the next byte.
// Each character is read from the token store and then loaded into the output
// register. run_last marks the final beat caused by a byte.
module script_token_splitter #(
	parameter int unsigned TOKEN_MAX = stsp_pkg::TOKEN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	stsp_in_if.sink     in_ch,
	stsp_out_if.source  out_ch
);

	stsp_pkg::cmd_t  cmd;
	stsp_pkg::stat_t stat;
	logic            ready;

	assign in_ch.ready = ready;

	stsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_byte  (in_ch.in_byte),
		.in_ready (ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stsp_datapath #(
		.TOKEN_MAX(TOKEN_MAX)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (in_ch.in_byte),
		.cmd     (cmd),
		.stat    (stat),
		.out_ch  (out_ch)
	);

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for script_token_splitter: text bytes go in on in_ch and token beats
// come back on out_ch, where they are checked against a predictor kept in step with the input.
// Depends on stsp_pkg, the stsp_in_if/stsp_out_if interfaces and the script_token_splitter RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HOLD_MAX = stsp_pkg::TOKEN_MAX_DEF;

	typedef enum logic [2:0] {
		SCAN_SKIP,
		SCAN_SLASH,
		SCAN_COMMENT,
		SCAN_QUOTE,
		SCAN_WORD
	} scan_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [4:0] pos;
		logic       last;
	} token_beat_t;

	logic clk;
	logic arst_n;

	stsp_in_if  in_ch();
	stsp_out_if out_ch();

	script_token_splitter DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	logic [7:0]  text_bytes[$];
	token_beat_t tokens_due[$];
	bit          failed;
	bit          byte_taken;
	bit          calm;
	int unsigned send_gap;
	int unsigned recv_stall;

	// Predictor state: what the splitter should hold between bytes.
	scan_t       scan;
	logic [7:0]  held_chars[HOLD_MAX];
	int unsigned held_len;

	function automatic void hold_char(input logic [7:0] c);
		if (held_len < HOLD_MAX) begin
			held_chars[held_len] = c;
			held_len++;
		end
	endfunction

	function automatic void send_token();
		if (held_len == 0) begin
			tokens_due.push_back('{kind: stsp_pkg::KIND_EMPTY, value: 8'h00, pos: 5'd0,
				last: 1'b0});
		end else begin
			for (int unsigned i = 0; i < held_len; i++)
				tokens_due.push_back('{kind: stsp_pkg::KIND_CHAR, value: held_chars[i],
					pos: 5'(i), last: 1'b0});
		end
	endfunction

	function automatic void split_byte(input logic [7:0] c);
		int unsigned before_count;
		bit          ended;
		before_count = tokens_due.size();
		ended = 1'b0;
		if (scan == SCAN_SLASH) begin
			if (c == stsp_pkg::CH_SLASH) begin
				scan = SCAN_COMMENT;
				held_len = 0;
				return;
			end
			scan = SCAN_WORD;
		end
		case (scan)
			SCAN_COMMENT: begin
				if (c == stsp_pkg::CH_NUL)
					ended = 1'b1;
				else if (c == stsp_pkg::CH_NL)
					scan = SCAN_SKIP;
			end
			SCAN_QUOTE: begin
				if (c == stsp_pkg::CH_QUOTE) begin
					send_token();
					scan = SCAN_SKIP;
				end else if (c == stsp_pkg::CH_NUL) begin
					send_token();
					ended = 1'b1;
				end else begin
					hold_char(c);
				end
			end
			SCAN_WORD: begin
				if (c > stsp_pkg::CH_SPACE) begin
					hold_char(c);
				end else begin
					// A word that filled the store is dropped and reported as empty.
					if (held_len >= HOLD_MAX)
						held_len = 0;
					send_token();
					scan = SCAN_SKIP;
					if (c == stsp_pkg::CH_NUL)
						ended = 1'b1;
				end
			end
			default: begin
				if (c == stsp_pkg::CH_NUL) begin
					ended = 1'b1;
				end else if (c <= stsp_pkg::CH_SPACE) begin
				end else if (c == stsp_pkg::CH_SLASH) begin
					held_len = 0;
					hold_char(c);
					scan = SCAN_SLASH;
				end else if (c == stsp_pkg::CH_QUOTE) begin
					held_len = 0;
					scan = SCAN_QUOTE;
				end else begin
					held_len = 0;
					hold_char(c);
					scan = SCAN_WORD;
				end
			end
		endcase
		if (ended) begin
			tokens_due.push_back('{kind: stsp_pkg::KIND_END, value: 8'h00, pos: 5'd0,
				last: 1'b0});
			scan = SCAN_SKIP;
			held_len = 0;
		end
		if (tokens_due.size() > before_count)
			tokens_due[tokens_due.size() - 1].last = 1'b1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Take note of every accepted input beat and predict what it causes.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			split_byte(in_ch.in_byte);
			byte_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || byte_taken)) begin
			byte_taken = 1'b0;
			if (send_gap > 0) begin
				in_ch.valid <= 1'b0;
				send_gap--;
			end else if (text_bytes.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				in_ch.valid <= 1'b0;
				send_gap = $urandom_range(1, 8) - 1;
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.in_byte <= text_bytes.pop_front();
			end
		end
		if (text_bytes.size() < 30)
			calm = 1'b1;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall > 0) begin
				out_ch.ready <= 1'b0;
				recv_stall--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				recv_stall = $urandom_range(1, 8) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		token_beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (tokens_due.size() == 0) begin
				$error("unexpected beat: kind %0d value %0h index %0d last %0d",
					out_ch.item_kind, out_ch.char_value, out_ch.char_index, out_ch.run_last);
				failed = 1'b1;
			end else begin
				want = tokens_due.pop_front();
				if (out_ch.item_kind !== want.kind) begin
					$error("item_kind: expected %0d, got %0d", want.kind, out_ch.item_kind);
					failed = 1'b1;
				end
				if (out_ch.char_value !== want.value) begin
					$error("char_value: expected %0h, got %0h", want.value, out_ch.char_value);
					failed = 1'b1;
				end
				if (out_ch.char_index !== want.pos) begin
					$error("char_index: expected %0d, got %0d", want.pos, out_ch.char_index);
					failed = 1'b1;
				end
				if (out_ch.run_last !== want.last) begin
					$error("run_last: expected %0d, got %0d", want.last, out_ch.run_last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned len;
		logic [7:0]  c;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		failed = 1'b0;
		byte_taken = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		recv_stall = 0;
		scan = SCAN_SKIP;
		held_len = 0;

		// Directed text: empty quotes, an all-ones word, a word opening with a slash, a comment,
		// end right after a word, end in a comment, end in a quote, a slash right before
		// the end, and a blank followed by the end.
		text_bytes = '{stsp_pkg::CH_SPACE, stsp_pkg::CH_QUOTE, stsp_pkg::CH_QUOTE, 8'hFF,
			stsp_pkg::CH_SPACE, stsp_pkg::CH_SLASH, "x", stsp_pkg::CH_NL,
			stsp_pkg::CH_SLASH, stsp_pkg::CH_SLASH, "c", stsp_pkg::CH_NL, "w",
			stsp_pkg::CH_NUL, stsp_pkg::CH_SLASH, stsp_pkg::CH_SLASH, stsp_pkg::CH_NUL,
			stsp_pkg::CH_QUOTE, "q", stsp_pkg::CH_NUL, stsp_pkg::CH_SLASH,
			stsp_pkg::CH_NUL, 8'h01, stsp_pkg::CH_NUL};

		while (text_bytes.size() < 150) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 3))
						text_bytes.push_back(8'($urandom_range(1, 32)));
				end
				2, 3, 4: begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34)
						: $urandom_range(1, 6);
					// The opening beat may be a slash as long as a second slash does not follow.
					if ($urandom_range(0, 3) == 0) begin
						text_bytes.push_back(stsp_pkg::CH_SLASH);
						for (int unsigned i = 1; i < len; i++) begin
							do c = 8'($urandom_range(33, 255));
							while (i == 1 && c == stsp_pkg::CH_SLASH);
							text_bytes.push_back(c);
						end
					end else begin
						do c = 8'($urandom_range(33, 255));
						while (c == stsp_pkg::CH_SLASH || c == stsp_pkg::CH_QUOTE);
						text_bytes.push_back(c);
						for (int unsigned i = 1; i < len; i++)
							text_bytes.push_back(8'($urandom_range(33, 255)));
					end
					text_bytes.push_back(($urandom_range(0, 7) == 0) ? stsp_pkg::CH_NUL
						: 8'($urandom_range(1, 32)));
				end
				5, 6: begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 35)
						: $urandom_range(0, 5);
					text_bytes.push_back(stsp_pkg::CH_QUOTE);
					repeat (len) begin
						do c = 8'($urandom_range(1, 255));
						while (c == stsp_pkg::CH_QUOTE);
						text_bytes.push_back(c);
					end
					text_bytes.push_back(($urandom_range(0, 7) == 0) ? stsp_pkg::CH_NUL
						: stsp_pkg::CH_QUOTE);
				end
				7: begin
					text_bytes.push_back(stsp_pkg::CH_SLASH);
					text_bytes.push_back(stsp_pkg::CH_SLASH);
					repeat ($urandom_range(0, 5)) begin
						do c = 8'($urandom_range(1, 255));
						while (c == stsp_pkg::CH_NL);
						text_bytes.push_back(c);
					end
					text_bytes.push_back(($urandom_range(0, 7) == 0) ? stsp_pkg::CH_NUL
						: stsp_pkg::CH_NL);
				end
				8: begin
					repeat ($urandom_range(1, 4))
						text_bytes.push_back(8'($urandom_range(0, 255)));
				end
				default: text_bytes.push_back(stsp_pkg::CH_NUL);
			endcase
		end

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		while (text_bytes.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (!failed && tokens_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
